FILE: hdl/bst_pkg.sv
// Shared types, codes and constants for the bounded set table.
package bst_pkg;

  localparam int KEY_W           = 32;
  localparam int KIND_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int FILL_W          = 6;
  localparam int DEF_TABLE_DEPTH = 32;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_DUP     = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] last;
  } probe_t;

  // Write strobe broadcast to the cells
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] data;
  } wr_t;

endpackage

FILE: hdl/bst_req_if.sv
// Request channel: operation kind and value.
interface bst_req_if
  import bst_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [KEY_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

FILE: hdl/bst_rsp_if.sv
// Response channel: status, found flag and fill count.
interface bst_rsp_if
  import bst_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, status, found, fill_count, input ready);
  modport sink   (input valid, status, found, fill_count, output ready);
endinterface

FILE: hdl/bst_cell.sv
// One table slot: holds an entry and compares it against the passing search token.
module bst_cell
  import bst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int IDX         = 0
) (
  input  logic                                           clk,
  input  probe_t                                         probe_in,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] slot_in,
  output probe_t                                         probe_out,
  output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] slot_out,
  input  logic [$clog2(TABLE_DEPTH + 1)-1:0]             occ,
  input  wr_t                                            wr,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [IDX_W-1:0] SLOT     = IDX_W'(IDX);
  localparam logic [OCC_W-1:0] POS      = OCC_W'(IDX);
  localparam logic [OCC_W-1:0] LAST_OCC = OCC_W'(IDX + 1);

  logic [KEY_W-1:0] entry;
  logic             held;
  logic             is_last;
  logic             match;

  // Slot is live only below the fill count
  assign held    = (POS < occ);
  assign is_last = (LAST_OCC == occ);
  assign match   = held && (entry == probe_in.key);

  // Token stage: pick up hit, slot and the last live entry
  always_ff @(posedge clk) begin
    probe_out.hit  <= probe_in.hit | match;
    probe_out.key  <= probe_in.key;
    probe_out.last <= is_last ? entry : probe_in.last;
    slot_out       <= match ? SLOT : slot_in;
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (wr.en && (wr_addr == SLOT)) begin
      entry <= wr.data;
    end
  end

endmodule

FILE: hdl/bounded_set_table.sv
// Top level of the bounded set table: controller, cell chain and result register.
//
// A set of up to TABLE_DEPTH distinct 32-bit values kept in a row of cells with
// a fill count. Each request (insert, erase, lookup, clear) gives one response
// with status, found flag and the fill count after the operation. A request
// sends a search token down the chain of TABLE_DEPTH cells, one cell per cycle,
// then writes back and loads the response register; no new request is taken
// until that write-back is done. The response register lets the next request
// start while the previous response waits; a request only stalls in its
// write-back cycle if the earlier response is still unread.
// No clearing pass is needed after reset.
module bounded_set_table
  import bst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  bst_req_if.sink  req,
  bst_rsp_if.source rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] CNT_LAST  = IDX_W'(TABLE_DEPTH - 1);

  state_t             state;
  state_t             state_next;
  logic [IDX_W-1:0]   cnt;
  kind_t              kind_r;
  logic [KEY_W-1:0]   key_r;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_next;

  logic                out_valid;
  status_t             out_status;
  logic                out_found;
  logic [FILL_W-1:0]   out_fill;

  logic                req_take;
  logic                out_free;
  logic                commit;
  status_t             status_next;
  wr_t                 wr;
  logic                wr_hit;
  logic [IDX_W-1:0]    wr_addr;
  logic [OCC_W+FILL_W-1:0] fill_ext;

  probe_t           chain      [TABLE_DEPTH+1];
  logic [IDX_W-1:0] slot_chain [TABLE_DEPTH+1];

  // Chain head: token for the held request
  assign chain[0]      = '{hit: 1'b0, key: key_r, last: '0};
  assign slot_chain[0] = '0;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      bst_cell #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX         (gi)
      ) u_cell (
        .clk       (clk),
        .probe_in  (chain[gi]),
        .slot_in   (slot_chain[gi]),
        .probe_out (chain[gi+1]),
        .slot_out  (slot_chain[gi+1]),
        .occ       (occ),
        .wr        (wr),
        .wr_addr   (wr_addr)
      );
    end
  endgenerate

  // Handshake outputs
  always_comb begin
    req.ready = (state == ST_IDLE);
    out_free  = !out_valid || rsp.ready;
    commit    = (state == ST_UPDATE) && out_free;
    req_take  = req.valid && req.ready;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_take) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (cnt == CNT_LAST) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Operation outcome once the token leaves the last cell
  always_comb begin
    status_next = STAT_OK;
    occ_next    = occ;
    wr_hit      = 1'b0;
    wr_addr     = slot_chain[TABLE_DEPTH];
    wr.data     = key_r;
    case (kind_r)
      KIND_INSERT: begin
        if (chain[TABLE_DEPTH].hit) begin
          status_next = STAT_DUP;
        end else if (occ == OCC_FULL) begin
          status_next = STAT_FULL;
        end else begin
          wr_hit   = 1'b1;
          wr_addr  = occ[IDX_W-1:0];
          occ_next = occ + 1'b1;
        end
      end
      KIND_ERASE: begin
        if (!chain[TABLE_DEPTH].hit) begin
          status_next = STAT_MISSING;
        end else begin
          // Last live entry moves into the freed slot
          wr_hit   = 1'b1;
          wr.data  = chain[TABLE_DEPTH].last;
          occ_next = occ - 1'b1;
        end
      end
      KIND_LOOKUP: begin
        status_next = STAT_OK;
      end
      KIND_CLEAR: begin
        occ_next = '0;
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
    wr.en = wr_hit && commit;
  end

  assign fill_ext = {{FILL_W{1'b0}}, occ_next};

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SEARCH) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (commit) begin
        occ <= occ_next;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and response payload
  always_ff @(posedge clk) begin
    if (req_take) begin
      kind_r <= kind_t'(req.kind);
      key_r  <= req.value;
    end
    if (commit) begin
      out_status <= status_next;
      out_found  <= chain[TABLE_DEPTH].hit;
      out_fill   <= fill_ext[FILL_W-1:0];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found      = out_found;
  assign rsp.fill_count = out_fill;

endmodule

FILE: hdl/bst_checker.sv
// Port-level checks for the bounded set table, bound to the top level.
module bst_checker
  import bst_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic                rsp_found,
  input logic [FILL_W-1:0]   rsp_fill
);

  localparam logic [FILL_W+10:0] DEPTH_EXT = (FILL_W + 11)'(TABLE_DEPTH);
  localparam logic [FILL_W-1:0]  FULL_FILL = DEPTH_EXT[FILL_W-1:0];

  // Search runs after every request transfer, so no back-to-back take
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a search was running");

  // Full report only when the table is at capacity and the value absent
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == STAT_FULL) |-> !rsp_found && (rsp_fill == FULL_FILL))
    else $error("full status with inconsistent found or fill count");

  // Duplicate implies found, missing implies absent
  a_status_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_status != STAT_DUP) || rsp_found) &&
                  ((rsp_status != STAT_MISSING) || !rsp_found))
    else $error("status disagrees with found flag");

  // A stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                $stable(rsp_found) && $stable(rsp_fill))
    else $error("stalled response changed");

endmodule

bind bounded_set_table bst_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_bst_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_found  (rsp.found),
  .rsp_fill   (rsp.fill_count)
);
